[rtl/longest_common_subsequence_assert.svh]
// assertion macros for the longest common subsequence block
`ifndef LONGEST_COMMON_SUBSEQUENCE_ASSERT_SVH
`define LONGEST_COMMON_SUBSEQUENCE_ASSERT_SVH

// same-cycle implication
`define LCS_ASSERT_IMPLY(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("lcs check failed: same cycle");

// next-cycle implication
`define LCS_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("lcs check failed: next cycle");

`endif

[rtl/lcs_pkg.sv]
// shared types and constants for the longest common subsequence block
package lcs_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int SYMBOL_BITS_DEF = 32;
    localparam int SYM_PORT_BITS   = 32;
    localparam int OP_BITS         = 2;

    typedef enum logic [1:0] {
        OP_APPEND_FIRST  = 2'd0,
        OP_APPEND_SECOND = 2'd1,
        OP_FINISH        = 2'd2,
        OP_NONE          = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_TRACE_READ,
        ST_TRACE_EVAL,
        ST_FLUSH
    } state_t;

endpackage

[rtl/longest_common_subsequence.sv]
// Longest common subsequence block. Append transactions (operation 0 or 1) are taken one per
// cycle. A finish transaction stalls input for a table fill through a chain of MAX_LEN column
// cells, the rows of the first list entering the chain in turn, last row first (no fill when
// either list is empty). The traceback then alternates a read state and an evaluate state
// (registered reads of the list and decision-bit memories) and can stall on output
// backpressure; a flush state then sends the final item. Input is ready again after that.
module longest_common_subsequence #(
    parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // symbol
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // symbol_res
    output logic        m_axis_tuser,   // none_common
    output logic        m_axis_tlast    // last
);

    localparam int LEN_BITS = $clog2(MAX_LEN + 1);
    localparam int IDX_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_BITS = $clog2(2 * MAX_LEN + 1);
    localparam int PB       = lcs_pkg::SYM_PORT_BITS;

    lcs_pkg::state_t state_reg, state_next;

    logic [LEN_BITS-1:0]    n1_reg, n2_reg;
    logic [LEN_BITS-1:0]    r_reg, c_reg;
    logic [CNT_BITS-1:0]    fcnt_reg;
    logic                   feed_valid_reg;
    logic [IDX_BITS-1:0]    feed_row_reg;
    logic [SYMBOL_BITS-1:0] first_mem [MAX_LEN];
    logic [SYMBOL_BITS-1:0] second_mem [MAX_LEN];
    logic [SYMBOL_BITS-1:0] f_q_reg, s_q_reg;
    logic                   hold_valid_reg;
    logic [SYMBOL_BITS-1:0] hold_sym_reg;
    logic                   m_valid_reg;
    logic [PB-1:0]          m_data_reg;
    logic                   m_none_reg;
    logic                   m_last_reg;

    logic                   accept;
    logic                   app_first, app_second, finish;
    logic [SYMBOL_BITS-1:0] in_sym;
    logic [SYMBOL_BITS+PB-1:0] in_ext;
    logic [SYMBOL_BITS+PB-1:0] hold_ext;
    logic                   out_free;
    logic                   feeding;
    logic [LEN_BITS-1:0]    feed_row;
    logic [IDX_BITS-1:0]    f_addr;
    logic                   match;
    logic                   eq_sel;
    logic                   trace_done;
    logic                   ev_stall;

    logic                   c_valid [MAX_LEN+1];
    logic [SYMBOL_BITS-1:0] c_sym   [MAX_LEN+1];
    logic [IDX_BITS-1:0]    c_row   [MAX_LEN+1];
    logic [LEN_BITS-1:0]    c_b     [MAX_LEN+1];
    logic [LEN_BITS-1:0]    c_d     [MAX_LEN+1];
    logic [MAX_LEN-1:0]     eq_bits;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign app_first  = accept && (s_axis_tuser == lcs_pkg::OP_APPEND_FIRST);
    assign app_second = accept && (s_axis_tuser == lcs_pkg::OP_APPEND_SECOND);
    assign finish     = accept && (s_axis_tuser == lcs_pkg::OP_FINISH);
    assign in_ext     = {{SYMBOL_BITS{1'b0}}, s_axis_tdata};
    assign in_sym     = in_ext[SYMBOL_BITS-1:0];
    assign hold_ext   = {{PB{1'b0}}, hold_sym_reg};
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign feeding    = (fcnt_reg < CNT_BITS'(n1_reg));
    assign feed_row   = n1_reg - LEN_BITS'(1) - fcnt_reg[LEN_BITS-1:0];
    assign f_addr     = (state_reg == lcs_pkg::ST_FILL) ? feed_row[IDX_BITS-1:0]
                                                        : r_reg[IDX_BITS-1:0];
    assign match      = (f_q_reg == s_q_reg);
    assign eq_sel     = eq_bits[c_reg[IDX_BITS-1:0]];
    assign trace_done = (r_reg >= n1_reg) || (c_reg >= n2_reg);
    assign ev_stall   = match && hold_valid_reg && !out_free;

    // cell chain, entering at the highest column
    assign c_valid[MAX_LEN] = feed_valid_reg;
    assign c_sym[MAX_LEN]   = f_q_reg;
    assign c_row[MAX_LEN]   = feed_row_reg;
    assign c_b[MAX_LEN]     = '0;
    assign c_d[MAX_LEN]     = '0;

    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        lcs_cell #(
            .SYMBOL_BITS (SYMBOL_BITS),
            .MAX_LEN     (MAX_LEN),
            .LEN_BITS    (LEN_BITS),
            .IDX_BITS    (IDX_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (finish),
            .load      (app_second && (n2_reg == LEN_BITS'(g))),
            .load_sym  (in_sym),
            .active    (LEN_BITS'(g) < n2_reg),
            .in_valid  (c_valid[g+1]),
            .in_sym    (c_sym[g+1]),
            .in_row    (c_row[g+1]),
            .in_b      (c_b[g+1]),
            .in_d      (c_d[g+1]),
            .out_valid (c_valid[g]),
            .out_sym   (c_sym[g]),
            .out_row   (c_row[g]),
            .out_b     (c_b[g]),
            .out_d     (c_d[g]),
            .rd_addr   (r_reg[IDX_BITS-1:0]),
            .eq_bit    (eq_bits[g])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcs_pkg::ST_IDLE:
            begin
                if (finish)
                begin
                    state_next = ((n1_reg != '0) && (n2_reg != '0)) ? lcs_pkg::ST_FILL
                                                                     : lcs_pkg::ST_FLUSH;
                end
            end
            lcs_pkg::ST_FILL:
            begin
                if (fcnt_reg == CNT_BITS'(n1_reg) + CNT_BITS'(MAX_LEN - 1))
                begin
                    state_next = lcs_pkg::ST_TRACE_READ;
                end
            end
            lcs_pkg::ST_TRACE_READ:
            begin
                state_next = trace_done ? lcs_pkg::ST_FLUSH : lcs_pkg::ST_TRACE_EVAL;
            end
            lcs_pkg::ST_TRACE_EVAL:
            begin
                if (!ev_stall)
                begin
                    state_next = lcs_pkg::ST_TRACE_READ;
                end
            end
            lcs_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = lcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        case (state_reg)
            lcs_pkg::ST_IDLE: s_axis_tready = 1'b1;
            default:          s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lcs_pkg::ST_IDLE;
            n1_reg         <= '0;
            n2_reg         <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            fcnt_reg       <= '0;
            feed_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            feed_valid_reg <= (state_reg == lcs_pkg::ST_FILL) && feeding;
            if (((state_reg == lcs_pkg::ST_TRACE_EVAL) && !ev_stall && match && hold_valid_reg)
                || ((state_reg == lcs_pkg::ST_FLUSH) && out_free))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (app_first && (n1_reg < LEN_BITS'(MAX_LEN)))
            begin
                n1_reg <= n1_reg + LEN_BITS'(1);
            end
            if (app_second && (n2_reg < LEN_BITS'(MAX_LEN)))
            begin
                n2_reg <= n2_reg + LEN_BITS'(1);
            end
            if (finish)
            begin
                fcnt_reg <= '0;
                r_reg    <= '0;
                c_reg    <= '0;
            end
            if (state_reg == lcs_pkg::ST_FILL)
            begin
                fcnt_reg <= fcnt_reg + CNT_BITS'(1);
            end
            if ((state_reg == lcs_pkg::ST_TRACE_EVAL) && !ev_stall)
            begin
                if (match)
                begin
                    r_reg          <= r_reg + LEN_BITS'(1);
                    c_reg          <= c_reg + LEN_BITS'(1);
                    hold_valid_reg <= 1'b1;
                end
                else if (eq_sel)
                begin
                    r_reg <= r_reg + LEN_BITS'(1);
                end
                else
                begin
                    c_reg <= c_reg + LEN_BITS'(1);
                end
            end
            if ((state_reg == lcs_pkg::ST_FLUSH) && out_free)
            begin
                hold_valid_reg <= 1'b0;
                n1_reg         <= '0;
                n2_reg         <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (app_first && (n1_reg < LEN_BITS'(MAX_LEN)))
        begin
            first_mem[n1_reg[IDX_BITS-1:0]] <= in_sym;
        end
        if (app_second && (n2_reg < LEN_BITS'(MAX_LEN)))
        begin
            second_mem[n2_reg[IDX_BITS-1:0]] <= in_sym;
        end
        f_q_reg      <= first_mem[f_addr];
        s_q_reg      <= second_mem[c_reg[IDX_BITS-1:0]];
        feed_row_reg <= feed_row[IDX_BITS-1:0];
        if ((state_reg == lcs_pkg::ST_TRACE_EVAL) && !ev_stall && match)
        begin
            hold_sym_reg <= f_q_reg;
            if (hold_valid_reg)
            begin
                m_data_reg <= hold_ext[PB-1:0];
                m_none_reg <= 1'b0;
                m_last_reg <= 1'b0;
            end
        end
        if ((state_reg == lcs_pkg::ST_FLUSH) && out_free)
        begin
            m_data_reg <= hold_valid_reg ? hold_ext[PB-1:0] : '0;
            m_none_reg <= !hold_valid_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_none_reg;
    assign m_axis_tlast  = m_last_reg;

`include "longest_common_subsequence_assert.svh"

    `LCS_ASSERT_IMPLY(a_none_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    `LCS_ASSERT_IMPLY(a_trace_in_range, state_reg == lcs_pkg::ST_TRACE_EVAL, !trace_done)
    `LCS_ASSERT_NEXT(a_fill_exit, state_reg == lcs_pkg::ST_FILL,
        state_reg == lcs_pkg::ST_FILL || state_reg == lcs_pkg::ST_TRACE_READ)

endmodule

[rtl/lcs_cell.sv]
// one column cell of the lcs table fill chain with its decision bit store
module lcs_cell #(
    parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF,
    parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
    parameter int LEN_BITS    = $clog2(MAX_LEN + 1),
    parameter int IDX_BITS    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic                   load,
    input  logic [SYMBOL_BITS-1:0] load_sym,
    input  logic                   active,
    input  logic                   in_valid,
    input  logic [SYMBOL_BITS-1:0] in_sym,
    input  logic [IDX_BITS-1:0]    in_row,
    input  logic [LEN_BITS-1:0]    in_b,
    input  logic [LEN_BITS-1:0]    in_d,
    output logic                   out_valid,
    output logic [SYMBOL_BITS-1:0] out_sym,
    output logic [IDX_BITS-1:0]    out_row,
    output logic [LEN_BITS-1:0]    out_b,
    output logic [LEN_BITS-1:0]    out_d,
    input  logic [IDX_BITS-1:0]    rd_addr,
    output logic                   eq_bit
);

    logic [SYMBOL_BITS-1:0] sym_reg;
    logic [LEN_BITS-1:0]    up_reg;
    logic                   out_valid_reg;
    logic [SYMBOL_BITS-1:0] out_sym_reg;
    logic [IDX_BITS-1:0]    out_row_reg;
    logic [LEN_BITS-1:0]    out_b_reg;
    logic [LEN_BITS-1:0]    out_d_reg;
    logic                   eq_bit_reg;
    logic                   eq_mem [MAX_LEN];
    logic [LEN_BITS-1:0]    v;

    always_comb
    begin
        if (!active)
        begin
            v = '0;
        end
        else if (in_sym == sym_reg)
        begin
            v = in_d + LEN_BITS'(1);
        end
        else
        begin
            v = (up_reg > in_b) ? up_reg : in_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid;
            if (clear)
            begin
                up_reg <= '0;
            end
            else if (in_valid)
            begin
                up_reg <= v;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sym_reg <= load_sym;
        end
        out_sym_reg <= in_sym;
        out_row_reg <= in_row;
        out_b_reg   <= v;
        out_d_reg   <= up_reg;
        if (in_valid)
        begin
            eq_mem[in_row] <= (v == up_reg);
        end
        eq_bit_reg <= eq_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_sym   = out_sym_reg;
    assign out_row   = out_row_reg;
    assign out_b     = out_b_reg;
    assign out_d     = out_d_reg;
    assign eq_bit    = eq_bit_reg;

endmodule
